// ----- src/mtg_pkg.sv -----
// ----------------------------------------------------------------------------
// mtg_pkg: shared constants for the Mersenne Twister generator
// Widths, the table depth, the recurrence constants and the tap position
// used by the interfaces, the cell row and the twist unit.
// ----------------------------------------------------------------------------
package mtg_pkg;

    // Word and field widths.
    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 24;

    // Table depth and the distance of the far tap.
    localparam int TABLE_WORDS = 624;
    localparam int SHIFT_DIST  = 397;

    // Twist constants.
    localparam logic [WORD_W-1:0] TWIST_XOR = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] HIGH_BIT  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS  = 32'h7fff_ffff;

    // Seeding constants.
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

    // Tempering masks.
    localparam logic [WORD_W-1:0] TEMPER_B = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C = 32'hefc6_0000;

    // Request function codes.
    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_SEED = 1'b1;

endpackage

// ----- src/mtg_ifs.sv -----
// ----------------------------------------------------------------------------
// mtg_ifs: handshake channels of the Mersenne Twister generator
// A request channel that carries the function and seed, and a response
// channel that carries the tempered word and its fraction.
// ----------------------------------------------------------------------------
interface mtg_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [mtg_pkg::WORD_W-1:0]  seed_value;

    modport source (output valid, output func, output seed_value, input ready);
    modport sink   (input valid, input func, input seed_value, output ready);
endinterface

interface mtg_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [mtg_pkg::WORD_W-1:0]  word;
    logic [mtg_pkg::FRAC_W-1:0]  fraction;

    modport source (output valid, output word, output fraction, input ready);
    modport sink   (input valid, input word, input fraction, output ready);
endinterface

// ----- src/mtg_cell.sv -----
// ----------------------------------------------------------------------------
// mtg_cell: one word of the state row
// Holds one 32-bit state word and takes its neighbor's word on each shift.
// ----------------------------------------------------------------------------
module mtg_cell (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [mtg_pkg::WORD_W-1:0] i_d,
    output logic [mtg_pkg::WORD_W-1:0] o_q
);

    logic [mtg_pkg::WORD_W-1:0] r_word;

    // Load the neighbor's word when the row moves.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_d;
        end
    end

    assign o_q = r_word;

endmodule

// ----- src/mtg_twist.sv -----
// ----------------------------------------------------------------------------
// mtg_twist: twist and temper of one state word
// Forms the twisted replacement for the oldest word from its neighbor and
// the far tap, and tempers that replacement into the output word.
// ----------------------------------------------------------------------------
module mtg_twist (
    input  logic [mtg_pkg::WORD_W-1:0] i_cur,
    input  logic [mtg_pkg::WORD_W-1:0] i_nxt,
    input  logic [mtg_pkg::WORD_W-1:0] i_far,
    output logic [mtg_pkg::WORD_W-1:0] o_twisted,
    output logic [mtg_pkg::WORD_W-1:0] o_tempered
);

    logic [mtg_pkg::WORD_W-1:0] w_y;
    logic [mtg_pkg::WORD_W-1:0] w_t1;
    logic [mtg_pkg::WORD_W-1:0] w_t2;
    logic [mtg_pkg::WORD_W-1:0] w_t3;

    // Splice the high bit of the current word onto the low bits of the next.
    assign w_y = (i_cur & mtg_pkg::HIGH_BIT) | (i_nxt & mtg_pkg::LOW_BITS);

    // The twisted word replaces the current one.
    assign o_twisted = i_far ^ (w_y >> 1) ^ (w_y[0] ? mtg_pkg::TWIST_XOR : '0);

    // Tempering of the new word.
    assign w_t1       = o_twisted ^ (o_twisted >> 11);
    assign w_t2       = w_t1 ^ ((w_t1 << 7) & mtg_pkg::TEMPER_B);
    assign w_t3       = w_t2 ^ ((w_t2 << 15) & mtg_pkg::TEMPER_C);
    assign o_tempered = w_t3 ^ (w_t3 >> 18);

endmodule

// ----- src/mersenne_twister_generator_core.sv -----
// A draw on a seeded generator is registered on acceptance and its result shows in the next cycle.
// Draws sustain one per cycle while the response side is ready; the state row moves one word per draw.
// A seed loads the seed value and then one multiply result per cycle into the row, and gives no result.
// A draw before any seed first runs the default seed and is then served as a deferred draw.
// Reset marks the generator unseeded; the state row itself is not cleared.
// ----------------------------------------------------------------------------
// mersenne_twister_generator_core: 32-bit Mersenne Twister generator
// The state lives in a circular row of word cells. Each draw twists the
// oldest word on the fly, feeds it back to the tail and returns its tempered
// value; seeding pushes the recurrence words in at the tail one per cycle.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_core #(
    parameter int TABLE_WORDS = mtg_pkg::TABLE_WORDS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mtg_req_if.sink      i_req,
    mtg_rsp_if.source    o_rsp
);

    localparam int CNT_W = $clog2(TABLE_WORDS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEED = 2'b10
    } t_state;

    t_state                      r_state, n_state;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_seeded, n_seeded;
    logic                        r_draw_pend, n_draw_pend;
    logic                        r_out_valid;
    logic [mtg_pkg::WORD_W-1:0]  r_out_word;

    logic                        w_fire;
    logic                        w_seed_start;
    logic                        w_dflt_start;
    logic                        w_draw;
    logic                        w_shift;
    logic [mtg_pkg::WORD_W-1:0]  w_tail;
    logic [mtg_pkg::WORD_W-1:0]  w_mix;
    logic [mtg_pkg::WORD_W-1:0]  w_knuth;
    logic [mtg_pkg::WORD_W-1:0]  w_twisted;
    logic [mtg_pkg::WORD_W-1:0]  w_tempered;
    logic [mtg_pkg::WORD_W-1:0]  w_q [TABLE_WORDS];

    // Request handshake: idle, no deferred draw, and room in the output register.
    assign i_req.ready  = (r_state == ST_IDLE) && !r_draw_pend
                          && (!r_out_valid || o_rsp.ready);
    assign w_fire       = i_req.valid && i_req.ready;
    assign w_seed_start = w_fire && (i_req.func == mtg_pkg::FUNC_SEED);
    assign w_dflt_start = w_fire && (i_req.func == mtg_pkg::FUNC_DRAW) && !r_seeded;
    assign w_draw       = (w_fire && (i_req.func == mtg_pkg::FUNC_DRAW) && r_seeded)
                          || ((r_state == ST_IDLE) && r_draw_pend);
    assign w_shift      = w_seed_start || w_dflt_start || (r_state == ST_SEED) || w_draw;

    // Seeding recurrence on the newest word.
    assign w_mix   = w_q[TABLE_WORDS-1] ^ (w_q[TABLE_WORDS-1] >> 30);
    assign w_knuth = (mtg_pkg::SEED_MULT * w_mix)
                     + {{(mtg_pkg::WORD_W-CNT_W){1'b0}}, r_cnt};

    // Twist of the oldest word.
    mtg_twist u_twist (
        .i_cur      (w_q[0]),
        .i_nxt      (w_q[1]),
        .i_far      (w_q[mtg_pkg::SHIFT_DIST]),
        .o_twisted  (w_twisted),
        .o_tempered (w_tempered)
    );

    // Word entering the tail of the row.
    always_comb begin
        if (w_seed_start) begin
            w_tail = i_req.seed_value;
        end else if (w_dflt_start) begin
            w_tail = mtg_pkg::DEFAULT_SEED;
        end else if (r_state == ST_SEED) begin
            w_tail = w_knuth;
        end else begin
            w_tail = w_twisted;
        end
    end

    // Row of state cells, oldest word at index zero.
    for (genvar g = 0; g < TABLE_WORDS; g++) begin : g_cell
        if (g == TABLE_WORDS - 1) begin : g_tail
            mtg_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_d     (w_tail),
                .o_q     (w_q[g])
            );
        end else begin : g_body
            mtg_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_d     (w_q[g+1]),
                .o_q     (w_q[g])
            );
        end
    end

    // Control next state.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_seeded    = r_seeded;
        n_draw_pend = r_draw_pend;
        case (r_state)
            ST_IDLE: begin
                if (w_seed_start || w_dflt_start) begin
                    n_state     = ST_SEED;
                    n_cnt       = CNT_W'(1);
                    n_seeded    = 1'b1;
                    n_draw_pend = w_dflt_start;
                end else if (w_draw) begin
                    n_draw_pend = 1'b0;
                end
            end
            ST_SEED: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(TABLE_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_seeded    <= 1'b0;
            r_draw_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_seeded    <= n_seeded;
            r_draw_pend <= n_draw_pend;
            if (w_draw) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (w_draw) begin
            r_out_word <= w_tempered;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.word     = r_out_word;
    assign o_rsp.fraction = r_out_word[mtg_pkg::FRAC_W-1:0];

    // A draw only loads the output register when it is free or being emptied.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_draw |-> (!r_out_valid || o_rsp.ready))
        else $error("draw overwrote a pending response");

    // No request is taken while seeding.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEED) |-> !i_req.ready)
        else $error("request accepted during seeding");

    // The seed counter stays within the table while seeding.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEED) |-> (r_cnt != '0) && (r_cnt < CNT_W'(TABLE_WORDS)))
        else $error("seed counter out of range");

    // A deferred draw is only pending once the generator is marked seeded.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draw_pend |-> r_seeded)
        else $error("deferred draw without seeding");

    // Starting a seed moves the controller into seeding on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_seed_start || w_dflt_start) |=> (r_state == ST_SEED))
        else $error("seed did not start");

endmodule

// ----- tb/mtg_draw_checker.sv -----
// ----------------------------------------------------------------------------
// mtg_draw_checker: scoreboard for the Mersenne Twister generator
// Watches the request and response channels. Every accepted request updates
// a private copy of the generator state, and each draw queues the tempered
// word it should produce. Every accepted response is compared field by field
// with the oldest queued word.
// ----------------------------------------------------------------------------
module mtg_draw_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mtg_req_if    i_req,
    mtg_rsp_if    i_rsp,
    output int    o_fail_count,
    output int    o_pending
);

    // Position that marks a generator that has never been seeded.
    localparam int UNSEEDED_POS = mtg_pkg::TABLE_WORDS + 1;

    typedef struct packed {
        logic [mtg_pkg::WORD_W-1:0] word;
        logic [mtg_pkg::FRAC_W-1:0] fraction;
    } t_draw_result;

    // Private copy of the generator state.
    logic [mtg_pkg::WORD_W-1:0] mt_state [mtg_pkg::TABLE_WORDS];
    int                         mt_pos;

    t_draw_result               expected_draws [$];
    int                         mismatches;

    // Fill the table with the multiplier recurrence and mark it used up.
    function automatic void seed_state(input logic [mtg_pkg::WORD_W-1:0] seed);
        logic [mtg_pkg::WORD_W-1:0] p;
        mt_state[0] = seed;
        for (int i = 1; i < mtg_pkg::TABLE_WORDS; i++) begin
            p           = mt_state[i-1];
            mt_state[i] = mtg_pkg::SEED_MULT * (p ^ (p >> 30)) + 32'(i);
        end
        mt_pos = mtg_pkg::TABLE_WORDS;
    endfunction

    // Regenerate the whole table in place, one word after another.
    function automatic void twist_state();
        logic [mtg_pkg::WORD_W-1:0] nxt;
        logic [mtg_pkg::WORD_W-1:0] far;
        logic [mtg_pkg::WORD_W-1:0] y;
        for (int k = 0; k < mtg_pkg::TABLE_WORDS; k++) begin
            nxt         = mt_state[(k + 1) % mtg_pkg::TABLE_WORDS];
            far         = mt_state[(k + mtg_pkg::SHIFT_DIST) % mtg_pkg::TABLE_WORDS];
            y           = (mt_state[k] & mtg_pkg::HIGH_BIT) | (nxt & mtg_pkg::LOW_BITS);
            mt_state[k] = far ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_XOR : '0);
        end
        mt_pos = 0;
    endfunction

    // Output tempering of one table word.
    function automatic logic [mtg_pkg::WORD_W-1:0] temper_word(
        input logic [mtg_pkg::WORD_W-1:0] w
    );
        logic [mtg_pkg::WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
        y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Apply one accepted request to the state and queue its draw, if any.
    function automatic void apply_request(input logic func,
                                          input logic [mtg_pkg::WORD_W-1:0] seed);
        t_draw_result r;
        if (func == mtg_pkg::FUNC_SEED) begin
            seed_state(seed);
        end else begin
            // A draw on an unseeded or used-up table refills it first.
            if (mt_pos >= mtg_pkg::TABLE_WORDS) begin
                if (mt_pos == UNSEEDED_POS) begin
                    seed_state(mtg_pkg::DEFAULT_SEED);
                end
                twist_state();
            end
            r.word     = temper_word(mt_state[mt_pos]);
            r.fraction = r.word[mtg_pkg::FRAC_W-1:0];
            mt_pos++;
            expected_draws = {expected_draws, r};
        end
    endfunction

    // Count a failure and report the first few of them.
    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // Compare one accepted response with the oldest queued draw.
    function automatic void check_draw(input logic [mtg_pkg::WORD_W-1:0] word,
                                       input logic [mtg_pkg::FRAC_W-1:0] fraction);
        t_draw_result exp;
        if (expected_draws.size() == 0) begin
            note_failure($sformatf("unexpected response: word %08h fraction %06h",
                                   word, fraction));
        end else begin
            exp = expected_draws.pop_front();
            if (word !== exp.word) begin
                note_failure($sformatf("word mismatch: expected %08h got %08h",
                                       exp.word, word));
            end
            if (fraction !== exp.fraction) begin
                note_failure($sformatf("fraction mismatch: expected %06h got %06h",
                                       exp.fraction, fraction));
            end
        end
    endfunction

    // Monitor both channels. A response can never belong to a request that
    // is accepted at the same edge, so the response side is handled first.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mt_pos = UNSEEDED_POS;
            expected_draws.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                check_draw(i_rsp.word, i_rsp.fraction);
            end
            if (i_req.valid && i_req.ready) begin
                apply_request(i_req.func, i_req.seed_value);
            end
        end
        o_pending    <= expected_draws.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- tb/tb_mersenne_twister_generator_core.sv -----
// ----------------------------------------------------------------------------
// tb_mersenne_twister_generator_core: testbench of the Mersenne Twister core
// Sends a directed set of seeds and draws, then random segments that mix seeds
// and draw runs, some long enough to use up the table. The sender
// works in bursts and the receiver stalls on its own pattern, with long
// hold-offs that back the core up. A checker module scores every response.
// ----------------------------------------------------------------------------
module tb_mersenne_twister_generator_core;

    // Number of request transactions the stimulus aims for.
    localparam int TARGET_ITEMS = 1450;

    logic i_clk;
    logic i_rst_n;

    int   fail_count;
    int   pending_draws;

    int   items_sent;
    int   burst_left;

    mtg_req_if req_ch ();
    mtg_rsp_if rsp_ch ();

    mersenne_twister_generator_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    mtg_draw_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_draws)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #60000000;
        $display("tb_mersenne_twister_generator_core failed");
        $finish;
    end

    // Decide the gap after each transaction: bursts of random length, some of
    // them long and without gaps, separated by random idle stretches.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 400)
                                                     : $urandom_range(1, 40);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(0, 6);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Offer one request and wait for its transaction.
    task automatic send_req(input logic func, input logic [mtg_pkg::WORD_W-1:0] seed);
        req_ch.valid      <= 1'b1;
        req_ch.func       <= func;
        req_ch.seed_value <= seed;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        items_sent++;
        pace_sender();
    endtask

    // A run of draws; the ignored seed field carries random values. The run
    // is cut short once the item budget is spent.
    task automatic draw_run(input int count);
        repeat (count) begin
            if (items_sent < TARGET_ITEMS) begin
                send_req(mtg_pkg::FUNC_DRAW, $urandom());
            end
        end
    endtask

    // Seed values that favor the extremes and single-bit patterns.
    function automatic logic [mtg_pkg::WORD_W-1:0] pick_seed();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(0, 31);
            3:       return mtg_pkg::DEFAULT_SEED;
            default: return $urandom();
        endcase
    endfunction

    // Run length of draws: mostly short, sometimes past the end of the table.
    function automatic int pick_run();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(600, 700)
                                           : $urandom_range(1, 40);
    endfunction

    // Receiver: a stall pattern that changes per window, plus two long
    // hold-offs once enough responses have gone through.
    initial begin
        int mode;
        int window_left;
        int hold_left;
        int holds_done;
        int draws_taken;
        int phase;
        mode        = 0;
        window_left = 0;
        hold_left   = 0;
        holds_done  = 0;
        draws_taken = 0;
        phase       = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                draws_taken++;
            end
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (holds_done < 2 && draws_taken >= (holds_done == 0 ? 200 : 900)) begin
                holds_done++;
                hold_left = 200;
                rsp_ch.ready <= 1'b0;
            end else begin
                if (window_left == 0) begin
                    mode        = $urandom_range(0, 4);
                    window_left = (mode == 4) ? $urandom_range(1, 8)
                                              : $urandom_range(10, 80);
                end
                window_left--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= $urandom_range(0, 1);
                    2:       rsp_ch.ready <= (phase % 4 == 0);
                    3:       rsp_ch.ready <= ($urandom_range(0, 7) != 0);
                    default: rsp_ch.ready <= 1'b0;
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int seg;
        items_sent = 0;
        burst_left = $urandom_range(1, 20);
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= mtg_pkg::FUNC_DRAW;
        req_ch.seed_value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: draws before any seed, extreme seeds, back-to-back
        // reseeding and reseeding in the middle of the table.
        send_req(mtg_pkg::FUNC_DRAW, '1);
        send_req(mtg_pkg::FUNC_DRAW, '0);
        send_req(mtg_pkg::FUNC_DRAW, $urandom());
        send_req(mtg_pkg::FUNC_SEED, '0);
        draw_run(2);
        send_req(mtg_pkg::FUNC_SEED, '1);
        draw_run(2);
        send_req(mtg_pkg::FUNC_SEED, mtg_pkg::HIGH_BIT);
        send_req(mtg_pkg::FUNC_SEED, mtg_pkg::DEFAULT_SEED);
        draw_run(2);
        send_req(mtg_pkg::FUNC_SEED, 32'h1);
        send_req(mtg_pkg::FUNC_DRAW, '1);
        send_req(mtg_pkg::FUNC_SEED, mtg_pkg::LOW_BITS);
        draw_run(3);
        send_req(mtg_pkg::FUNC_SEED, $urandom());
        send_req(mtg_pkg::FUNC_DRAW, '0);

        // Random part. The first segment always runs past the table end.
        send_req(mtg_pkg::FUNC_SEED, pick_seed());
        draw_run($urandom_range(630, 700));
        while (items_sent < TARGET_ITEMS) begin
            seg = $urandom_range(0, 9);
            if (seg < 7) begin
                send_req(mtg_pkg::FUNC_SEED, pick_seed());
                draw_run(pick_run());
            end else if (seg == 7) begin
                draw_run(pick_run());
            end else if (seg == 8) begin
                send_req(mtg_pkg::FUNC_SEED, pick_seed());
                send_req(mtg_pkg::FUNC_SEED, pick_seed());
                draw_run(pick_run());
            end else begin
                draw_run($urandom_range(1, 20));
                send_req(mtg_pkg::FUNC_SEED, pick_seed());
                draw_run($urandom_range(1, 20));
            end
        end
        req_ch.valid <= 1'b0;

        // Let the checker count the last transaction, drain the outstanding
        // draws, then watch a little longer for strays.
        repeat (2) @(posedge i_clk);
        while (pending_draws != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending_draws == 0) begin
            $display("tb_mersenne_twister_generator_core passed");
        end else begin
            $display("tb_mersenne_twister_generator_core failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/mtg_pkg.sv
src/mtg_ifs.sv
src/mtg_cell.sv
src/mtg_twist.sv
src/mersenne_twister_generator_core.sv
tb/mtg_draw_checker.sv
tb/tb_mersenne_twister_generator_core.sv
